>>> hdl/barometric_pressure_compensation_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation block
// Expects clk and rst_n in the scope where a macro is used.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int CFG_AW     = 5;
  localparam int TEMP_ROUND = 8;
  localparam int B6_OFFSET  = 4000;
  localparam int B4_BIAS    = 32768;
  localparam int B7_SCALE   = 50000;
  localparam int PC_SQ      = 3038;
  localparam int PC_LIN     = -7357;
  localparam int PC_OFS     = 3791;
  localparam int P_MAX      = 262143;

  // temperature division: |mc*2048| by |x1+md|
  localparam int TDIV_NW = 27;
  localparam int TDIV_DW = 18;
  localparam int TDIV_QW = 27;
  // pressure division: |b7| or |2*b7| by |b4|, quotient below 2^21
  localparam int PDIV_NW = 63;
  localparam int PDIV_DW = 45;
  localparam int PDIV_QW = 21;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic        [1:0]  oss;
  } cfg_t;

  // travels through the temperature divider
  typedef struct packed {
    logic signed [17:0] x1;
    logic        [23:0] up;
    logic               dz;
    logic               neg;
  } tside_t;

  // temperature result and flags carried along the pressure path
  typedef struct packed {
    logic signed [15:0] t;
    logic               tsat;
    logic               dz;
    logic        [23:0] up;
  } ctx_t;

  // travels through the pressure divider
  typedef struct packed {
    logic signed [15:0] t;
    logic               tsat;
    logic               dz;
    logic               b4z;
    logic               case1;
    logic               neg;
    logic               ovf;
  } pside_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic        [17:0] pressure_pa;
    status_t            status;
  } result_t;

endpackage

>>> hdl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if / bpc_out_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic        [17:0] pressure_pa;
  logic        [1:0]  status;

  modport source (output valid, temperature_tenths, pressure_pa, status, input ready);
  modport sink   (input valid, temperature_tenths, pressure_pa, status, output ready);
endinterface

>>> hdl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw reading (16-bit temperature word, 24-bit pressure
//   bytes); out_ch returns temperature in 0.1 degC, pressure in Pa and a
//   status code (ok, divide by zero, saturated). Both are valid/ready.
//   Calibration words and oversampling are written over the APB port while
//   the block is idle; the user must keep to this, as the block does not
//   enforce it; reads return the stored values. From acceptance, an item
//   passes 3 front stages, 27 stages of the temperature divider, 8
//   polynomial stages, 21 stages of the pressure divider and 3 correction
//   stages ending in the output register. One item is accepted per cycle
//   unless out_ch stalls; the one-bit-per-stage dividers set the depth.
//   Reset clears all valid bits and loads calibration zeros and oversampling
//   3. When the receiver holds ready low with a result waiting, the whole
//   pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  bpc_in_if.sink                      in_ch,
  bpc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bpc_pkg::*;

  cfg_t               cfg;
  logic               en;
  logic               f_vld, td_vld, p_vld, pd_vld, c_vld;
  logic [TDIV_NW-1:0] f_num;
  logic [TDIV_DW-1:0] f_den;
  tside_t             f_side, td_side;
  logic [TDIV_QW-1:0] td_quo;
  logic [PDIV_NW-1:0] p_num;
  logic [PDIV_DW-1:0] p_den;
  pside_t             p_side, pd_side;
  logic [PDIV_QW-1:0] pd_quo;
  result_t            c_res;

  // advance everything unless a result is waiting on a stalled receiver
  assign en          = !c_vld || out_ch.ready;
  assign in_ch.ready = en;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_ch.valid),
    .raw_temperature (in_ch.raw_temperature),
    .raw_pressure    (in_ch.raw_pressure),
    .cfg             (cfg),
    .out_valid       (f_vld),
    .num             (f_num),
    .den             (f_den),
    .side            (f_side)
  );

  bpc_udiv #(
    .NW (TDIV_NW),
    .DW (TDIV_DW),
    .QW (TDIV_QW),
    .SW ($bits(tside_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_vld),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (td_vld),
    .quo       (td_quo),
    .side_out  (td_side)
  );

  bpc_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (td_vld),
    .quo       (td_quo),
    .side_in   (td_side),
    .cfg       (cfg),
    .out_valid (p_vld),
    .num       (p_num),
    .den       (p_den),
    .side_out  (p_side)
  );

  bpc_udiv #(
    .NW (PDIV_NW),
    .DW (PDIV_DW),
    .QW (PDIV_QW),
    .SW ($bits(pside_t))
  ) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_vld),
    .num       (p_num),
    .den       (p_den),
    .side_in   (p_side),
    .out_valid (pd_vld),
    .quo       (pd_quo),
    .side_out  (pd_side)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pd_vld),
    .quo       (pd_quo),
    .side_in   (pd_side),
    .out_valid (c_vld),
    .res       (c_res)
  );

  assign out_ch.valid              = c_vld;
  assign out_ch.temperature_tenths = c_res.temperature_tenths;
  assign out_ch.pressure_pa        = c_res.pressure_pa;
  assign out_ch.status             = c_res.status;

endmodule

>>> hdl/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg
// APB register file holding calibration words and oversampling.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_macros.svh"

module bpc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bpc_pkg::cfg_t                cfg
);
  import bpc_pkg::*;

  logic [31:0] cal_ac1_ac2_r;
  logic [31:0] cal_ac3_ac4_r;
  logic [31:0] cal_ac5_ac6_r;
  logic [31:0] cal_b1_b2_r;
  logic [31:0] cal_mc_md_r;
  logic [1:0]  oss_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_ac1_ac2_r <= '0;
      cal_ac3_ac4_r <= '0;
      cal_ac5_ac6_r <= '0;
      cal_b1_b2_r   <= '0;
      cal_mc_md_r   <= '0;
      oss_r         <= 2'd3;
    end else if (wr_en) begin
      unique case (idx)
        REG_AC1_AC2: cal_ac1_ac2_r <= pwdata;
        REG_AC3_AC4: cal_ac3_ac4_r <= pwdata;
        REG_AC5_AC6: cal_ac5_ac6_r <= pwdata;
        REG_B1_B2:   cal_b1_b2_r   <= pwdata;
        REG_MC_MD:   cal_mc_md_r   <= pwdata;
        REG_OSS:     oss_r         <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AC1_AC2: prdata = cal_ac1_ac2_r;
      REG_AC3_AC4: prdata = cal_ac3_ac4_r;
      REG_AC5_AC6: prdata = cal_ac5_ac6_r;
      REG_B1_B2:   prdata = cal_b1_b2_r;
      REG_MC_MD:   prdata = cal_mc_md_r;
      REG_OSS:     prdata = {30'd0, oss_r};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.ac1 = cal_ac1_ac2_r[31:16];
    cfg.ac2 = cal_ac1_ac2_r[15:0];
    cfg.ac3 = cal_ac3_ac4_r[31:16];
    cfg.ac4 = cal_ac3_ac4_r[15:0];
    cfg.ac5 = cal_ac5_ac6_r[31:16];
    cfg.ac6 = cal_ac5_ac6_r[15:0];
    cfg.b1  = cal_b1_b2_r[31:16];
    cfg.b2  = cal_b1_b2_r[15:0];
    cfg.mc  = cal_mc_md_r[31:16];
    cfg.md  = cal_mc_md_r[15:0];
    cfg.oss = oss_r;
  end

  `BPC_ASSERT_NEXT(a_oss_write, wr_en && (idx == REG_OSS), oss_r == $past(pwdata[1:0]), "oss write lost")

endmodule

>>> hdl/bpc_udiv.sv
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bpc_udiv #(
  parameter int NW = 27,
  parameter int DW = 18,
  parameter int QW = 27,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);
  localparam int RW = DW + QW;

  logic [RW-1:0] rem_r  [QW-1];
  logic [DW-1:0] den_r  [QW-1];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [RW-1:0] shifted;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] quo_nxt;
    logic [SW-1:0] side_in_s;
    logic          vld_in;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in    = RW'(num);
      assign den_in    = den;
      assign quo_in    = '0;
      assign side_in_s = side_in;
      assign vld_in    = in_valid;
    end else begin : g_next
      assign rem_in    = rem_r[i-1];
      assign den_in    = den_r[i-1];
      assign quo_in    = quo_r[i-1];
      assign side_in_s = side_r[i-1];
      assign vld_in    = vld_r[i-1];
    end

    assign shifted = RW'(den_in) << (QW - 1 - i);
    assign take    = rem_in >= shifted;

    always_comb begin
      quo_nxt = quo_in;
      quo_nxt[QW-1-i] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i]  <= quo_nxt;
        side_r[i] <= side_in_s;
      end
    end

    // the last stage needs no remainder or divisor
    if (i < QW - 1) begin : g_rem
      logic [RW-1:0] rem_nxt;
      assign rem_nxt = take ? (rem_in - shifted) : rem_in;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

>>> hdl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Input register, x1 product and setup of the temperature division.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [15:0]                   raw_temperature,
  input  logic [23:0]                   raw_pressure,
  input  bpc_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic [bpc_pkg::TDIV_NW-1:0]   num,
  output logic [bpc_pkg::TDIV_DW-1:0]   den,
  output bpc_pkg::tside_t               side
);
  import bpc_pkg::*;

  logic               s0_vld_r, s1_vld_r, s2_vld_r;
  logic [15:0]        ut_r;
  logic [23:0]        up0_r, up1_r;
  logic [23:0]        up_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [17:0] x1;
  logic signed [18:0] d;
  logic signed [26:0] mc_num;
  logic [TDIV_NW-1:0] num_nxt, num_r;
  logic [TDIV_DW-1:0] den_nxt, den_r;
  tside_t             side_nxt, side_r;

  assign up_nxt   = raw_pressure >> (4'd8 - 4'(cfg.oss));
  assign prod_nxt = 34'($signed({1'b0, ut_r}) - $signed({1'b0, cfg.ac6}))
                  * 34'($signed({1'b0, cfg.ac5}));

  always_comb begin
    x1      = 18'(prod_r >>> 15);
    d       = 19'(x1) + 19'(cfg.md);
    mc_num  = {cfg.mc, 11'd0};
    num_nxt = mc_num[26] ? TDIV_NW'(-mc_num) : TDIV_NW'(mc_num);
    den_nxt = d[18] ? TDIV_DW'(-d) : TDIV_DW'(d);
    side_nxt.x1  = x1;
    side_nxt.up  = up1_r;
    side_nxt.dz  = (d == '0);
    side_nxt.neg = mc_num[26] ^ d[18];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ut_r   <= raw_temperature;
      up0_r  <= up_nxt;
      prod_r <= prod_nxt;
      up1_r  <= up0_r;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign num       = num_r;
  assign den       = den_r;
  assign side      = side_r;

endmodule

>>> hdl/bpc_poly.sv
// ----------------------------------------------------------------------------
// bpc_poly
// Temperature result and the b3/b4/b7 polynomial, ending in the setup of
// the pressure division.
// ----------------------------------------------------------------------------
module bpc_poly (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bpc_pkg::TDIV_QW-1:0]   quo,
  input  bpc_pkg::tside_t               side_in,
  input  bpc_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic [bpc_pkg::PDIV_NW-1:0]   num,
  output logic [bpc_pkg::PDIV_DW-1:0]   den,
  output bpc_pkg::pside_t               side_out
);
  import bpc_pkg::*;

  logic [7:0] vld_r;

  // stage 1: x2, b5, temperature, b6
  logic signed [27:0] qs, x2, b5, b6_nxt, b6_r;
  logic signed [23:0] tf;
  ctx_t               ctx1_nxt, ctx1_r;
  // stage 2
  logic signed [55:0] sqf_r;
  logic signed [43:0] ac2b6_2_r, ac3b6_2_r;
  ctx_t               ctx2_r;
  // stage 3
  logic signed [42:0] sq;
  logic signed [58:0] b2sq_r, b1sq_r;
  logic signed [43:0] ac2b6_3_r, ac3b6_3_r;
  ctx_t               ctx3_r;
  // stage 4
  logic signed [48:0] x3a;
  logic signed [50:0] s3;
  logic signed [53:0] sh, sh2;
  logic signed [51:0] b3_nxt, b3_r;
  logic signed [41:0] x3b;
  logic signed [42:0] xb_nxt, xb_r;
  ctx_t               ctx4_r;
  // stage 5
  logic signed [59:0] b4p_r;
  logic signed [52:0] diff_r;
  ctx_t               ctx5_r;
  // stage 6
  logic [15:0]        scale;
  logic signed [44:0] b4_r;
  logic signed [63:0] b7_r;
  ctx_t               ctx6_r;
  // stage 7
  logic signed [63:0] nn;
  logic               case1_nxt;
  logic [PDIV_NW-1:0] nabs_r;
  logic [PDIV_DW-1:0] babs_r;
  logic               neg_r, b4z_r, case1_r;
  ctx_t               ctx7_r;
  // stage 8
  logic [PDIV_NW-1:0] num_r;
  logic [PDIV_DW-1:0] den_r;
  pside_t             side_nxt, side_r;

  always_comb begin
    qs = $signed({1'b0, quo});
    x2 = side_in.neg ? -qs : qs;
    b5 = 28'(side_in.x1) + x2;
    tf = 24'((b5 + 28'(TEMP_ROUND)) >>> 4);
    b6_nxt = b5 - 28'(B6_OFFSET);
    ctx1_nxt.dz = side_in.dz;
    ctx1_nxt.up = side_in.up;
    if (tf > 24'sd32767) begin
      ctx1_nxt.t    = 16'sh7fff;
      ctx1_nxt.tsat = 1'b1;
    end else if (tf < -24'sd32768) begin
      ctx1_nxt.t    = 16'sh8000;
      ctx1_nxt.tsat = 1'b1;
    end else begin
      ctx1_nxt.t    = 16'(tf);
      ctx1_nxt.tsat = 1'b0;
    end
  end

  assign sq = 43'(sqf_r >>> 12);

  always_comb begin
    x3a    = 49'(b2sq_r >>> 11) + 49'(ac2b6_3_r >>> 11);
    s3     = 51'(x3a) + (51'(cfg.ac1) <<< 2);
    sh     = 54'(s3) <<< cfg.oss;
    sh2    = sh + 54'sd2;
    // divide by four, rounding toward zero
    b3_nxt = sh2[53] ? 52'((sh2 + 54'sd3) >>> 2) : 52'(sh2 >>> 2);
    x3b    = 42'((44'(ac3b6_3_r >>> 13) + 44'(b1sq_r >>> 16) + 44'sd2) >>> 2);
    xb_nxt = 43'(x3b) + 43'(B4_BIAS);
  end

  assign scale = 16'(B7_SCALE >> cfg.oss);

  always_comb begin
    // small non-negative b7 keeps the doubled numerator, else double the quotient
    case1_nxt = (b7_r[63:31] == '0);
    nn        = case1_nxt ? (b7_r <<< 1) : b7_r;
  end

  always_comb begin
    side_nxt.t     = ctx7_r.t;
    side_nxt.tsat  = ctx7_r.tsat;
    side_nxt.dz    = ctx7_r.dz;
    side_nxt.b4z   = b4z_r;
    side_nxt.case1 = case1_r;
    side_nxt.neg   = neg_r;
    side_nxt.ovf   = {3'd0, nabs_r} >= {babs_r, 21'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b6_r      <= b6_nxt;
      ctx1_r    <= ctx1_nxt;

      sqf_r     <= 56'(b6_r) * 56'(b6_r);
      ac2b6_2_r <= 44'(cfg.ac2) * 44'(b6_r);
      ac3b6_2_r <= 44'(cfg.ac3) * 44'(b6_r);
      ctx2_r    <= ctx1_r;

      b2sq_r    <= 59'(cfg.b2) * 59'(sq);
      b1sq_r    <= 59'(cfg.b1) * 59'(sq);
      ac2b6_3_r <= ac2b6_2_r;
      ac3b6_3_r <= ac3b6_2_r;
      ctx3_r    <= ctx2_r;

      b3_r      <= b3_nxt;
      xb_r      <= xb_nxt;
      ctx4_r    <= ctx3_r;

      b4p_r     <= 60'($signed({1'b0, cfg.ac4})) * 60'(xb_r);
      diff_r    <= 53'($signed({1'b0, ctx4_r.up})) - 53'(b3_r);
      ctx5_r    <= ctx4_r;

      b4_r      <= 45'(b4p_r >>> 15);
      b7_r      <= 64'(diff_r) * 64'($signed({1'b0, scale}));
      ctx6_r    <= ctx5_r;

      nabs_r    <= nn[63] ? PDIV_NW'(-nn) : PDIV_NW'(nn);
      babs_r    <= b4_r[44] ? PDIV_DW'(-b4_r) : PDIV_DW'(b4_r);
      neg_r     <= nn[63] ^ b4_r[44];
      b4z_r     <= (b4_r == '0);
      case1_r   <= case1_nxt;
      ctx7_r    <= ctx6_r;

      num_r     <= nabs_r;
      den_r     <= babs_r;
      side_r    <= side_nxt;
    end
  end

  assign out_valid = vld_r[7];
  assign num       = num_r;
  assign den       = den_r;
  assign side_out  = side_r;

endmodule

>>> hdl/bpc_corr.sv
// ----------------------------------------------------------------------------
// bpc_corr
// Final pressure correction, saturation, status and output register.
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_macros.svh"

module bpc_corr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bpc_pkg::PDIV_QW-1:0]   quo,
  input  bpc_pkg::pside_t               side_in,
  output logic                          out_valid,
  output bpc_pkg::result_t              res
);
  import bpc_pkg::*;

  logic [1:0]         vld_r;
  logic               res_vld_r;
  // stage 1
  logic [21:0]        m;
  logic signed [20:0] ms, p_nxt, p1_r, p2_r;
  logic               big_nxt, big1_r, big2_r;
  pside_t             side1_r, side2_r;
  // stage 2
  logic signed [12:0] a;
  logic signed [25:0] sq8_r;
  logic signed [19:0] lin_r;
  // stage 3
  logic signed [20:0] x1c;
  logic signed [23:0] csum, pf;
  result_t            res_nxt, res_r;

  always_comb begin
    m       = side_in.case1 ? {1'b0, quo} : {quo, 1'b0};
    big_nxt = side_in.ovf || (m[21:20] != 2'd0);
    ms      = $signed({1'b0, m[19:0]});
    p_nxt   = side_in.neg ? -ms : ms;
  end

  assign a = 13'(p1_r >>> 8);

  always_comb begin
    x1c  = 21'((40'(sq8_r) * 40'(PC_SQ)) >>> 16);
    csum = 24'(x1c) + 24'(lin_r) + 24'(PC_OFS);
    pf   = 24'(p2_r) + (csum >>> 4);

    res_nxt.temperature_tenths = side2_r.t;
    res_nxt.status             = side2_r.tsat ? ST_SAT : ST_OK;
    if (side2_r.dz) begin
      res_nxt.temperature_tenths = '0;
      res_nxt.pressure_pa        = '0;
      res_nxt.status             = ST_DIV0;
    end else if (side2_r.b4z) begin
      res_nxt.pressure_pa = '0;
      res_nxt.status      = ST_DIV0;
    end else if (big2_r) begin
      res_nxt.pressure_pa = side2_r.neg ? '0 : 18'(P_MAX);
      res_nxt.status      = ST_SAT;
    end else if (pf > 24'(P_MAX)) begin
      res_nxt.pressure_pa = 18'(P_MAX);
      res_nxt.status      = ST_SAT;
    end else if (pf < 24'sd0) begin
      res_nxt.pressure_pa = '0;
      res_nxt.status      = ST_SAT;
    end else begin
      res_nxt.pressure_pa = 18'(pf);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      res_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[0], in_valid};
      res_vld_r <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p_nxt;
      big1_r  <= big_nxt;
      side1_r <= side_in;

      sq8_r   <= 26'(a) * 26'(a);
      lin_r   <= 20'((37'(p1_r) * 37'(PC_LIN)) >>> 16);
      p2_r    <= p1_r;
      big2_r  <= big1_r;
      side2_r <= side1_r;

      res_r   <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign res       = res_r;

  `BPC_ASSERT_NEXT(a_hold_on_stall, !en, $stable(res_r) && $stable(res_vld_r), "result moved while stalled")
  `BPC_ASSERT_NOW(a_div0_zero_p, res_vld_r && (res_r.status == ST_DIV0), res_r.pressure_pa == '0, "div0 with pressure")

endmodule
